// ===== src/bdth_pkg.sv =====
`timescale 1ns / 1ps
// bdth_pkg: shared types and constants for the boost duty block.
// No dependencies.
package bdth_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_V_OUT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V_OUT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VB_RISE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VB_FALL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SAFE   = 3'd5;

  localparam int FALLBACK_DUTY = 127;

  typedef struct packed {
    logic load;    // latch samples, update target state
    logic mul;     // form full_scale * vin
    logic step;    // one restoring division step
    logic finish;  // check limits, load output register
  } dp_cmd_t;

endpackage

// ===== src/bdth_ctrl.sv =====
`timescale 1ns / 1ps
// bdth_ctrl: sequencer for the boost duty block.
// Depends on bdth_pkg (dp_cmd_t).
module bdth_ctrl #(
  parameter int DIV_STEPS = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bdth_pkg::dp_cmd_t cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             finish;

  assign in_ready = (state == S_IDLE);
  assign finish   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    cmd.mul    = (state == S_MUL);
    cmd.step   = (state == S_DIV);
    cmd.finish = finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt   <= CNT_W'(DIV_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/bdth_dp.sv =====
`timescale 1ns / 1ps
// bdth_dp: config registers, target hysteresis, multiplier, restoring
// divider and limit checks. Depends on bdth_pkg.
module bdth_dp #(
  parameter int ADC_BITS = 10,
  parameter int PWM_BITS = 8,
  parameter int CFG_W    = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bdth_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic [ADC_BITS-1:0]            vin_sample,
  input  logic [ADC_BITS-1:0]            battery_sample,
  input  bdth_pkg::dp_cmd_t              cmd,
  output logic [PWM_BITS-1:0]            duty,
  output logic                           target_is_high,
  output logic                           fell_back
);

  localparam int P = PWM_BITS + ADC_BITS;

  logic [ADC_BITS-1:0] v_low, v_high, vb_rise, vb_fall;
  logic [PWM_BITS-1:0] full_scale, max_safe;
  logic                target_high, target_high_next;

  logic [ADC_BITS-1:0] vin_r, divisor;
  logic [P-1:0]        dvd;
  logic [ADC_BITS-1:0] rem;
  logic [ADC_BITS:0]   rem_sh;
  logic [ADC_BITS+1:0] diff;
  logic                borrow;
  logic                over_fs;
  logic [PWM_BITS-1:0] duty_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_low      <= ADC_BITS'(512);
      v_high     <= ADC_BITS'(768);
      vb_rise    <= ADC_BITS'(700);
      vb_fall    <= ADC_BITS'(600);
      full_scale <= PWM_BITS'(255);
      max_safe   <= PWM_BITS'(230);
    end else if (cfg_write) begin
      case (cfg_index)
        bdth_pkg::REG_V_OUT_LOW:  v_low      <= ADC_BITS'(cfg_data);
        bdth_pkg::REG_V_OUT_HIGH: v_high     <= ADC_BITS'(cfg_data);
        bdth_pkg::REG_VB_RISE:    vb_rise    <= ADC_BITS'(cfg_data);
        bdth_pkg::REG_VB_FALL:    vb_fall    <= ADC_BITS'(cfg_data);
        bdth_pkg::REG_FULL_SCALE: full_scale <= PWM_BITS'(cfg_data);
        bdth_pkg::REG_MAX_SAFE:   max_safe   <= PWM_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    target_high_next = target_high;
    if (!target_high && (battery_sample >= vb_rise)) begin
      target_high_next = 1'b1;
    end else if (target_high && (battery_sample <= vb_fall)) begin
      target_high_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_high <= 1'b0;
    end else if (cmd.load) begin
      target_high <= target_high_next;
    end
  end

  // restoring division step
  assign rem_sh = {rem, dvd[P-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
  assign borrow = diff[ADC_BITS+1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vin_r   <= vin_sample;
      divisor <= target_high_next ? v_high : v_low;
    end
    if (cmd.mul) begin
      dvd <= P'(full_scale) * P'(vin_r);
      rem <= '0;
    end else if (cmd.step) begin
      dvd <= {dvd[P-2:0], ~borrow};
      rem <= borrow ? rem_sh[ADC_BITS-1:0] : diff[ADC_BITS-1:0];
    end
  end

  assign over_fs  = (divisor == '0) || (dvd > P'(full_scale));
  assign duty_raw = full_scale - dvd[PWM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      target_is_high <= target_high;
      if (over_fs || (duty_raw > max_safe)) begin
        duty      <= PWM_BITS'(bdth_pkg::FALLBACK_DUTY);
        fell_back <= 1'b1;
      end else begin
        duty      <= duty_raw;
        fell_back <= 1'b0;
      end
    end
  end

endmodule

// ===== src/boost_duty_with_target_hysteresis_top.sv =====
`timescale 1ns / 1ps
// Boost converter feed-forward duty with hysteretic output target.
// Depends on bdth_pkg, bdth_ctrl, bdth_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | in_valid / in_ready  | vin_sample, battery_sample
//  output  | out_valid / out_ready| duty, target_is_high, fell_back
//  config  | cfg_write            | cfg_index, cfg_data
//
// Each item passes through a multiply step, a radix-2 restoring divider that
// forms one quotient bit per cycle, and a limit-check step before its result
// is loaded into the output register. One item is in work at a time; the next
// is taken while the last result waits in the output register, and the
// limit-check step stalls until that result is taken.
// Synchronous reset loads the register defaults and selects the low target.
module boost_duty_with_target_hysteresis_top #(
  parameter int ADC_BITS = 10,
  parameter int PWM_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bdth_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [((ADC_BITS > PWM_BITS) ? ADC_BITS : PWM_BITS)-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ADC_BITS-1:0]            vin_sample,
  input  logic [ADC_BITS-1:0]            battery_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [PWM_BITS-1:0]            duty,
  output logic                           target_is_high,
  output logic                           fell_back
);

  localparam int CFG_W = (ADC_BITS > PWM_BITS) ? ADC_BITS : PWM_BITS;

  bdth_pkg::dp_cmd_t cmd;

  bdth_ctrl #(
    .DIV_STEPS(PWM_BITS + ADC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  bdth_dp #(
    .ADC_BITS(ADC_BITS),
    .PWM_BITS(PWM_BITS),
    .CFG_W   (CFG_W)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .vin_sample    (vin_sample),
    .battery_sample(battery_sample),
    .cmd           (cmd),
    .duty          (duty),
    .target_is_high(target_is_high),
    .fell_back     (fell_back)
  );

endmodule
